### sv/multi_priority_event_fifo_core_assert.svh
// ----------------------------------------------------------------------------
// multi_priority_event_fifo_core assertion macros
// Concurrent check wrappers; compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef MULTI_PRIORITY_EVENT_FIFO_CORE_ASSERT_SVH
`define MULTI_PRIORITY_EVENT_FIFO_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// property checked at every clock edge outside reset
`define MPEF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define MPEF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`else

`define MPEF_ASSERT(lbl, clk, rst_n, prop, msg)
`define MPEF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### sv/mpef_pkg.sv
// ----------------------------------------------------------------------------
// mpef_pkg
// Shared constants and types of the multi-level priority event queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mpef_pkg;

	localparam int DEPTH_DEF       = 32;
	localparam int LEVELS_DEF      = 4;
	localparam int EVENT_WIDTH_DEF = 32;

	localparam int LEVEL_PORT_W = 2;
	localparam int DATA_PORT_W  = 32;
	localparam int HW_PORT_W    = 5;
	localparam int HW_SAT       = 31;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} store_req_t;

	typedef struct packed {
		logic                 popped;
		logic                 overflow;
		logic                 all_empty;
		logic [HW_PORT_W-1:0] high_water;
	} ctrl_res_t;

endpackage

`default_nettype wire

### sv/mpef_store.sv
// ----------------------------------------------------------------------------
// mpef_store
// Event storage: one ring of DEPTH slots per level, registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mpef_store
	import mpef_pkg::*;
#(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int LEVELS      = LEVELS_DEF,
	parameter int EVENT_WIDTH = EVENT_WIDTH_DEF,
	localparam int PW = $clog2(DEPTH),
	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
	input  wire logic                   clk,
	input  wire store_req_t             req,
	input  wire logic [LW-1:0]          wr_lv,
	input  wire logic [PW-1:0]          wr_ptr,
	input  wire logic [EVENT_WIDTH-1:0] wr_data,
	input  wire logic [LW-1:0]          rd_lv,
	input  wire logic [PW-1:0]          rd_ptr,
	output logic [EVENT_WIDTH-1:0]      rd_data
);

	logic [EVENT_WIDTH-1:0] mem_q [LEVELS][DEPTH];
	logic [EVENT_WIDTH-1:0] rd_data_q;

	// push and pop never share a cycle, so write and read never collide
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[wr_lv][wr_ptr] <= wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem_q[rd_lv][rd_ptr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### sv/mpef_ctrl.sv
// ----------------------------------------------------------------------------
// mpef_ctrl
// Per-level pointers and high-water marks, level select and status.
// ----------------------------------------------------------------------------
`default_nettype none

module mpef_ctrl
	import mpef_pkg::*;
#(
	parameter int DEPTH  = DEPTH_DEF,
	parameter int LEVELS = LEVELS_DEF,
	localparam int PW = $clog2(DEPTH),
	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    item_vld,
	input  wire cmd_t                    cmd,
	input  wire logic [LEVEL_PORT_W-1:0] lvl,
	output store_req_t                   req,
	output logic [LW-1:0]                wr_lv,
	output logic [PW-1:0]                wr_ptr,
	output logic [LW-1:0]                rd_lv,
	output logic [PW-1:0]                rd_ptr,
	output logic [LW-1:0]                pop_lv,
	output ctrl_res_t                    res
);

	logic [PW-1:0] wp_q [LEVELS];
	logic [PW-1:0] rp_q [LEVELS];
	logic [PW-1:0] pk_q [LEVELS];
	logic [PW-1:0] wp_d [LEVELS];
	logic [PW-1:0] rp_d [LEVELS];
	logic [PW-1:0] pk_d [LEVELS];

	logic          lvl_ok;
	logic [LW-1:0] lvl_ix;
	logic          found;
	logic [LW-1:0] sel_lv;
	logic [PW-1:0] wp_cur;
	logic          full;
	logic          do_push;
	logic          do_pop;
	logic [PW-1:0] h;
	logic [PW-1:0] t;
	logic [PW:0]   len_w;
	logic [PW-1:0] len;
	logic [PW-1:0] pk_rep;

	function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign lvl_ok = int'(lvl) < LEVELS;
	assign lvl_ix = LW'(lvl);

	// highest non-empty level wins
	always_comb begin
		found  = 1'b0;
		sel_lv = '0;
		for (int i = 0; i < LEVELS; i++) begin
			if (wp_q[i] != rp_q[i]) begin
				found  = 1'b1;
				sel_lv = LW'(i);
			end
		end
	end

	always_comb begin
		wp_d = wp_q;
		rp_d = rp_q;
		pk_d = pk_q;
		req  = '0;

		wp_cur  = wp_q[lvl_ix];
		full    = next_slot(wp_cur) == rp_q[lvl_ix];
		do_push = item_vld && (cmd == CMD_PUSH) && lvl_ok;
		do_pop  = item_vld && (cmd == CMD_POP) && found;

		h = wp_q[sel_lv];
		t = rp_q[sel_lv];
		// queue length before removal; below DEPTH whenever the level is non-empty
		if (h > t) begin
			len_w = {1'b0, h} - {1'b0, t};
		end else begin
			len_w = (PW + 1)'(DEPTH) - {1'b0, t} + {1'b0, h};
		end
		len = PW'(len_w);

		if (do_push && !full) begin
			wp_d[lvl_ix] = next_slot(wp_cur);
			req.wr_en    = 1'b1;
		end
		if (do_pop) begin
			rp_d[sel_lv] = next_slot(t);
			if (len > pk_q[sel_lv]) begin
				pk_d[sel_lv] = len;
			end
			req.rd_en = 1'b1;
		end

		res.popped    = do_pop;
		res.overflow  = do_push && full;
		res.all_empty = 1'b1;
		for (int i = 0; i < LEVELS; i++) begin
			if (wp_d[i] != rp_d[i]) begin
				res.all_empty = 1'b0;
			end
		end

		pk_rep = pk_d[lvl_ix];
		if (!lvl_ok) begin
			res.high_water = '0;
		end else if (int'(pk_rep) > HW_SAT) begin
			res.high_water = HW_PORT_W'(HW_SAT);
		end else begin
			res.high_water = HW_PORT_W'(pk_rep);
		end
	end

	assign wr_lv  = lvl_ix;
	assign wr_ptr = wp_cur;
	assign rd_lv  = sel_lv;
	assign rd_ptr = t;
	assign pop_lv = sel_lv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				wp_q[i] <= '0;
				rp_q[i] <= '0;
				pk_q[i] <= '0;
			end
		end else begin
			wp_q <= wp_d;
			rp_q <= rp_d;
			pk_q <= pk_d;
		end
	end

endmodule

`default_nettype wire

### sv/multi_priority_event_fifo_core.sv
// An accepted item (start high, busy low) passes the vld_s1 and done_s2 registers to the done strobe.
// Throughput: one item per cycle; busy stays low, since pointer update, level select
// and store access for an item all complete in its vld_s1 execute stage.
// The receiver cannot stall: each result is valid for exactly the one done cycle.
// Reset clears pointers, high-water marks and pipeline valids; store contents are
// left as they are and are only read after a push has written them.
// ----------------------------------------------------------------------------
// multi_priority_event_fifo_core
// Strict-priority event queue with one ring FIFO and high-water mark per level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_priority_event_fifo_core_assert.svh"

module multi_priority_event_fifo_core
	import mpef_pkg::*;
#(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int LEVELS      = LEVELS_DEF,
	parameter int EVENT_WIDTH = EVENT_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic                    cmd,
	input  wire logic [LEVEL_PORT_W-1:0] priority_req,
	input  wire logic [DATA_PORT_W-1:0]  event_data,
	output logic                         done,
	output logic                         popped,
	output logic [DATA_PORT_W-1:0]       event_out,
	output logic [LEVEL_PORT_W-1:0]      event_level,
	output logic                         overflow,
	output logic                         all_empty,
	output logic [HW_PORT_W-1:0]         high_water
);

	localparam int PW = $clog2(DEPTH);
	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	logic                    accept;
	logic                    vld_s1;
	cmd_t                    cmd_s1;
	logic [LEVEL_PORT_W-1:0] lvl_s1;
	logic [DATA_PORT_W-1:0]  data_s1;

	store_req_t              req;
	logic [LW-1:0]           wr_lv;
	logic [PW-1:0]           wr_ptr;
	logic [LW-1:0]           rd_lv;
	logic [PW-1:0]           rd_ptr;
	logic [LW-1:0]           pop_lv;
	ctrl_res_t               res;
	logic [EVENT_WIDTH-1:0]  rd_data;

	logic                    done_s2;
	ctrl_res_t               res_s2;
	logic [LEVEL_PORT_W-1:0] lvl_s2;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			vld_s1  <= accept;
			done_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd_t'(cmd);
			lvl_s1  <= priority_req;
			data_s1 <= event_data;
		end
		if (vld_s1) begin
			res_s2 <= res;
			lvl_s2 <= res.popped ? LEVEL_PORT_W'(pop_lv) : '0;
		end
	end

	mpef_ctrl #(
		.DEPTH  (DEPTH),
		.LEVELS (LEVELS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_vld (vld_s1),
		.cmd      (cmd_s1),
		.lvl      (lvl_s1),
		.req      (req),
		.wr_lv    (wr_lv),
		.wr_ptr   (wr_ptr),
		.rd_lv    (rd_lv),
		.rd_ptr   (rd_ptr),
		.pop_lv   (pop_lv),
		.res      (res)
	);

	mpef_store #(
		.DEPTH       (DEPTH),
		.LEVELS      (LEVELS),
		.EVENT_WIDTH (EVENT_WIDTH)
	) u_store (
		.clk     (clk),
		.req     (req),
		.wr_lv   (wr_lv),
		.wr_ptr  (wr_ptr),
		.wr_data (EVENT_WIDTH'(data_s1)),
		.rd_lv   (rd_lv),
		.rd_ptr  (rd_ptr),
		.rd_data (rd_data)
	);

	assign done        = done_s2;
	assign popped      = res_s2.popped;
	assign event_out   = res_s2.popped ? DATA_PORT_W'(rd_data) : '0;
	assign event_level = lvl_s2;
	assign overflow    = res_s2.overflow;
	assign all_empty   = res_s2.all_empty;
	assign high_water  = res_s2.high_water;

	`MPEF_ASSERT_NEXT(a_accept_done, clk, arst_n, accept, ##1 done, "accepted item gave no result")
	`MPEF_ASSERT(a_done_src, clk, arst_n, done |-> $past(accept, 2), "result without an accepted item")
	`MPEF_ASSERT(a_pop_xor_ovf, clk, arst_n, done |-> !(popped && overflow), "pop and overflow together")
	`MPEF_ASSERT(a_ovf_not_empty, clk, arst_n, (done && overflow) |-> !all_empty, "full level seen as empty")

endmodule

`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives push and pop commands into the priority event queue with random
// idle gaps and compares every done strobe against a local queue model.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mpef_pkg::*;

	localparam int ITEM_TOTAL = 1750;
	localparam int STALL_LIMIT = 1000;
	localparam int PTR_W = $clog2(DEPTH_DEF);

	typedef struct {
		cmd_t                    op;
		logic [LEVEL_PORT_W-1:0] prio;
		logic [DATA_PORT_W-1:0]  word;
		int                      gap;
		bit                      settle;
	} stim_t;

	typedef struct packed {
		logic                    popped;
		logic [DATA_PORT_W-1:0]  word;
		logic [LEVEL_PORT_W-1:0] level;
		logic                    ovf;
		logic                    idle_all;
		logic [HW_PORT_W-1:0]    hw;
	} queue_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    cmd = CMD_PUSH;
	logic [LEVEL_PORT_W-1:0] priority_req = '0;
	logic [DATA_PORT_W-1:0]  event_data = '0;
	logic                    busy;
	logic                    done;
	logic                    popped;
	logic [DATA_PORT_W-1:0]  event_out;
	logic [LEVEL_PORT_W-1:0] event_level;
	logic                    overflow;
	logic                    all_empty;
	logic [HW_PORT_W-1:0]    high_water;

	// local copy of the queue state
	logic [DATA_PORT_W-1:0] level_slots [LEVELS_DEF][DEPTH_DEF];
	logic [PTR_W-1:0]       head_ptr [LEVELS_DEF] = '{default: '0};
	logic [PTR_W-1:0]       tail_ptr [LEVELS_DEF] = '{default: '0};
	logic [HW_PORT_W-1:0]   peak_len [LEVELS_DEF] = '{default: '0};

	stim_t         stim_q[$];
	stim_t         in_flight;
	queue_result_t pending_results[$];
	queue_result_t want;
	int            err_count = 0;
	int            quiet_cycles = 0;

	multi_priority_event_fifo_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.priority_req(priority_req),
		.event_data  (event_data),
		.done        (done),
		.popped      (popped),
		.event_out   (event_out),
		.event_level (event_level),
		.overflow    (overflow),
		.all_empty   (all_empty),
		.high_water  (high_water)
	);

	always #10 clk = ~clk;

	// applies one command to the local queues and returns what the block must report
	function automatic queue_result_t advance_queues(stim_t s);
		queue_result_t r;
		logic [PTR_W-1:0] nxt;
		logic [PTR_W-1:0] occ;
		r = '0;
		r.idle_all = 1'b1;
		if (s.op == CMD_PUSH) begin
			nxt = (head_ptr[s.prio] == PTR_W'(DEPTH_DEF - 1)) ? '0 : head_ptr[s.prio] + 1'b1;
			if (nxt == tail_ptr[s.prio]) begin
				r.ovf = 1'b1;
			end else begin
				level_slots[s.prio][head_ptr[s.prio]] = s.word;
				head_ptr[s.prio] = nxt;
			end
		end else begin
			for (int lv = LEVELS_DEF - 1; lv >= 0; lv--) begin
				if (!r.popped && head_ptr[lv] != tail_ptr[lv]) begin
					// ring length before removal; mod 2^PTR_W covers the wrap
					occ = head_ptr[lv] - tail_ptr[lv];
					if (occ > peak_len[lv])
						peak_len[lv] = occ;
					r.word = level_slots[lv][tail_ptr[lv]];
					r.level = LEVEL_PORT_W'(lv);
					r.popped = 1'b1;
					tail_ptr[lv] = (tail_ptr[lv] == PTR_W'(DEPTH_DEF - 1)) ? '0 : tail_ptr[lv] + 1'b1;
				end
			end
		end
		for (int lv = 0; lv < LEVELS_DEF; lv++)
			if (head_ptr[lv] != tail_ptr[lv])
				r.idle_all = 1'b0;
		r.hw = peak_len[s.prio];
		return r;
	endfunction

	function automatic stim_t make_item(cmd_t op, int prio, logic [DATA_PORT_W-1:0] word,
			int gap, bit settle);
		stim_t s;
		s.op = op;
		s.prio = LEVEL_PORT_W'(prio);
		s.word = word;
		s.gap = gap;
		s.settle = settle;
		return s;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int next_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		else if (pick < 90)
			return $urandom_range(1, 3);
		else if (pick < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(input string what, input logic [DATA_PORT_W-1:0] got,
			input logic [DATA_PORT_W-1:0] exp_val);
		$display("MISMATCH %s: got %0h, expected %0h", what, got, exp_val);
		err_count++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= CMD_PUSH;
			priority_req <= '0;
			event_data <= '0;
		end else begin
			if (start && !busy)
				pending_results.push_back(advance_queues(in_flight));
			if (!start || !busy) begin
				if (stim_q.size() == 0) begin
					start <= 1'b0;
				end else if (stim_q[0].gap > 0) begin
					stim_q[0].gap = stim_q[0].gap - 1;
					start <= 1'b0;
				end else if (stim_q[0].settle && pending_results.size() != 0) begin
					start <= 1'b0;
				end else begin
					in_flight = stim_q.pop_front();
					start <= 1'b1;
					cmd <= in_flight.op;
					priority_req <= in_flight.prio;
					event_data <= in_flight.word;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, event_out", event_out, '0);
			end else begin
				want = pending_results.pop_front();
				if (popped !== want.popped)
					report_mismatch("popped", DATA_PORT_W'(popped),
						DATA_PORT_W'(want.popped));
				if (event_out !== want.word)
					report_mismatch("event_out", event_out, want.word);
				if (event_level !== want.level)
					report_mismatch("event_level", DATA_PORT_W'(event_level),
						DATA_PORT_W'(want.level));
				if (overflow !== want.ovf)
					report_mismatch("overflow", DATA_PORT_W'(overflow),
						DATA_PORT_W'(want.ovf));
				if (all_empty !== want.idle_all)
					report_mismatch("all_empty", DATA_PORT_W'(all_empty),
						DATA_PORT_W'(want.idle_all));
				if (high_water !== want.hw)
					report_mismatch("high_water", DATA_PORT_W'(high_water),
						DATA_PORT_W'(want.hw));
			end
		end
	end

	// watchdog: cycles with neither an accepted item nor a result
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d idle cycles", quiet_cycles);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		int    seg;
		int    mode;
		int    lvl;
		int    len;
		bit    no_gaps;
		cmd_t  op;
		int    prio;

		// directed: empty pops, extreme words, priority order, drain to empty
		stim_q.push_back(make_item(CMD_POP, 0, 32'h0, 0, 1'b0));
		stim_q.push_back(make_item(CMD_POP, 3, 32'hFFFF_FFFF, 0, 1'b0));
		stim_q.push_back(make_item(CMD_PUSH, 0, 32'h0000_0000, 0, 1'b0));
		stim_q.push_back(make_item(CMD_PUSH, 0, 32'hFFFF_FFFF, 0, 1'b0));
		stim_q.push_back(make_item(CMD_PUSH, 3, 32'hA5A5_A5A5, 0, 1'b0));
		stim_q.push_back(make_item(CMD_PUSH, 1, 32'h5A5A_5A5A, 0, 1'b0));
		stim_q.push_back(make_item(CMD_PUSH, 2, 32'h0000_0001, 0, 1'b0));
		stim_q.push_back(make_item(CMD_PUSH, 2, 32'h8000_0000, 0, 1'b0));
		stim_q.push_back(make_item(CMD_POP, 3, 32'h0, 0, 1'b0));
		stim_q.push_back(make_item(CMD_POP, 2, 32'h0, 0, 1'b0));
		stim_q.push_back(make_item(CMD_POP, 1, 32'h0, 0, 1'b0));
		stim_q.push_back(make_item(CMD_POP, 0, 32'h0, 0, 1'b0));
		stim_q.push_back(make_item(CMD_POP, 0, 32'h0, 0, 1'b0));
		stim_q.push_back(make_item(CMD_POP, 2, 32'h0, 0, 1'b0));
		stim_q.push_back(make_item(CMD_POP, 1, 32'h0, 0, 1'b0));

		// random segments: fill bursts to reach overflow, drains to reach empty,
		// mixed traffic in between; the first segment is always a fill burst on one level
		seg = 0;
		while (stim_q.size() < ITEM_TOTAL) begin
			mode = (seg == 0) ? 0 : $urandom_range(0, 3);
			lvl = $urandom_range(0, LEVELS_DEF - 1);
			len = (mode == 0) ? $urandom_range(25, 45) : $urandom_range(10, 50);
			no_gaps = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < len; k++) begin
				op = CMD_PUSH;
				prio = $urandom_range(0, LEVELS_DEF - 1);
				case (mode)
					0: begin
						if ($urandom_range(0, 9) != 0)
							prio = lvl;
						else if ($urandom_range(0, 1) == 1)
							op = CMD_POP;
					end
					1: begin
						if ($urandom_range(0, 19) > 2)
							op = CMD_POP;
					end
					2: begin
						if ($urandom_range(0, 1) == 1)
							op = CMD_POP;
					end
					default: begin
						if ($urandom_range(0, 9) < 3)
							op = CMD_POP;
					end
				endcase
				stim_q.push_back(make_item(op, prio, $urandom(), no_gaps ? 0 : next_gap(),
					(k == 0) && (seg == 0 || $urandom_range(0, 9) == 0)));
			end
			seg++;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() != 0 || start)
			@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
